// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
package spq_pkg;
   localparam int CAPACITY = 16;
   localparam int IW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);

   localparam logic [2:0] REQ_INSERT = 3'd0;
   localparam logic [2:0] REQ_REMOVE = 3'd1;
   localparam logic [2:0] REQ_UPDATE = 3'd2;
   localparam logic [2:0] REQ_SERVE  = 3'd3;
   localparam logic [2:0] REQ_COUNT  = 3'd4;
   localparam logic [2:0] REQ_LIST   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [15:0] tag;
      logic [15:0] prio;
   } entry_type;
endpackage

// ----- rtl/core/spq_ram.sv -----
`timescale 1ns / 1ps
module spq_ram (
   input  logic                clock,
   input  logic                we,
   input  logic [spq_pkg::IW-1:0] waddr,
   input  spq_pkg::entry_type  wdata,
   input  logic [spq_pkg::IW-1:0] raddr,
   output spq_pkg::entry_type  rdata
);
   import spq_pkg::*;

   entry_type mem [CAPACITY];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/stable_priority_queue_table_top.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | Ports
// request  | in        | req_valid, req_ready, req_type, req_tag, req_prio
// response | out       | rsp_valid, rsp_ready, rsp_status, rsp_occupancy,
//          |           | rsp_entry_tag, rsp_entry_prio, rsp_last
// Entries live in a single-port-read memory with a registered read port.
// Count and unused codes go straight to the response state; insert, remove,
// serve and update walk the memory entry by entry through the read and write
// states; list emits a response per entry. Synchronous reset empties the
// table at once. A waiting response stalls only the step that must emit.
module stable_priority_queue_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [15:0] req_tag,
   input  logic signed [15:0] req_prio,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_occupancy,
   output logic [15:0] rsp_entry_tag,
   output logic signed [15:0] rsp_entry_prio,
   output logic        rsp_last
);
   import spq_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RD   = 5'b00010,
      S_WR   = 5'b00100,
      S_LIST = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [15:0]   tag_ff, tag_in, prio_ff, prio_in;
   logic [FW-1:0] cnt_ff, cnt_in, fill_ff, fill_in;
   logic          found_ff, found_in, ins_ff, ins_in;
   logic [1:0]    st_ff, st_in;
   logic [15:0]   etag_ff, etag_in, eprio_ff, eprio_in;
   logic          rv_ff, rv_in, rl_ff, rl_in;
   logic [1:0]    rs_ff, rs_in;
   logic [FW-1:0] ro_ff, ro_in;
   logic [15:0]   rt_ff, rt_in, rp_ff, rp_in;

   logic          we;
   logic [IW-1:0] waddr, raddr;
   entry_type     wdata, rdata;
   logic [FW-1:0] cnt_m1, fill_m1;
   logic          out_free;

   spq_ram u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   assign cnt_m1   = cnt_ff - FW'(1);
   assign fill_m1  = fill_ff - FW'(1);
   assign out_free = !rv_ff || rsp_ready;

   always_comb begin
      state_in = state_ff; op_in = op_ff; tag_in = tag_ff; prio_in = prio_ff;
      cnt_in = cnt_ff; fill_in = fill_ff; found_in = found_ff; ins_in = ins_ff;
      st_in = st_ff; etag_in = etag_ff; eprio_in = eprio_ff;
      rv_in = rv_ff && !rsp_ready; rl_in = rl_ff; rs_in = rs_ff; ro_in = ro_ff;
      rt_in = rt_ff; rp_in = rp_ff;
      we = 1'b0; waddr = cnt_ff[IW-1:0]; wdata = rdata; raddr = cnt_ff[IW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_type; tag_in = req_tag; prio_in = req_prio;
               st_in = ST_OK; etag_in = '0; eprio_in = '0;
               cnt_in = '0; found_in = 1'b0; ins_in = 1'b0;
               state_in = S_RD;
               unique case (req_type)
                  REQ_INSERT: begin
                     if (fill_ff == FW'(CAPACITY)) begin
                        st_in = ST_FULL; state_in = S_DONE;
                     end else begin
                        ins_in = 1'b1; cnt_in = fill_ff;
                     end
                  end
                  REQ_REMOVE, REQ_UPDATE: ;
                  REQ_SERVE, REQ_LIST: begin
                     if (fill_ff == '0) begin
                        st_in = ST_EMPTY; state_in = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RD: begin
            if (ins_ff) begin
               if (cnt_ff == '0) begin
                  we = 1'b1; waddr = '0; wdata = '{tag: tag_ff, prio: prio_ff};
                  fill_in = fill_ff + FW'(1); state_in = S_DONE;
               end else begin
                  raddr = cnt_m1[IW-1:0]; state_in = S_WR;
               end
            end else if (op_ff == REQ_LIST) begin
               state_in = S_WR;
            end else if (cnt_ff == fill_ff) begin
               if (found_ff) begin
                  fill_in = fill_m1;
               end
               if (op_ff == REQ_UPDATE) begin
                  if (!found_ff && fill_ff == FW'(CAPACITY)) begin
                     st_in = ST_FULL; state_in = S_DONE;
                  end else begin
                     ins_in = 1'b1; cnt_in = found_ff ? fill_m1 : fill_ff;
                  end
               end else begin
                  st_in = found_ff ? ST_OK : ST_NOTFOUND; state_in = S_DONE;
               end
            end else begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            if (ins_ff) begin
               we = 1'b1;
               if ($signed(rdata.prio) >= $signed(prio_ff)) begin
                  wdata = '{tag: tag_ff, prio: prio_ff};
                  fill_in = fill_ff + FW'(1); state_in = S_DONE;
               end else begin
                  cnt_in = cnt_m1; state_in = S_RD;
               end
            end else if (op_ff == REQ_LIST) begin
               state_in = S_LIST;
            end else begin
               // After the match every later entry moves down by one slot.
               if (found_ff) begin
                  we = 1'b1; waddr = cnt_m1[IW-1:0];
               end else if (op_ff == REQ_SERVE || rdata.tag == tag_ff) begin
                  found_in = 1'b1;
                  if (op_ff == REQ_SERVE) begin
                     etag_in = rdata.tag; eprio_in = rdata.prio;
                  end
               end
               cnt_in = cnt_ff + FW'(1); state_in = S_RD;
            end
         end
         S_LIST: begin
            if (out_free) begin
               rv_in = 1'b1; rs_in = ST_OK; ro_in = fill_ff;
               rt_in = rdata.tag; rp_in = rdata.prio;
               rl_in = (cnt_ff == fill_m1);
               cnt_in = cnt_ff + FW'(1);
               state_in = (cnt_ff == fill_m1) ? S_IDLE : S_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rv_in = 1'b1; rs_in = st_ff; ro_in = fill_ff;
               rt_in = etag_ff; rp_in = eprio_ff; rl_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rv_ff    <= rv_in;
      end
      op_ff <= op_in; tag_ff <= tag_in; prio_ff <= prio_in; cnt_ff <= cnt_in;
      found_ff <= found_in; ins_ff <= ins_in; st_ff <= st_in;
      etag_ff <= etag_in; eprio_ff <= eprio_in;
      rl_ff <= rl_in; rs_ff <= rs_in; ro_ff <= ro_in; rt_ff <= rt_in; rp_ff <= rp_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rv_ff;
   assign rsp_status     = rs_ff;
   assign rsp_occupancy  = 5'(ro_ff);
   assign rsp_entry_tag  = rt_ff;
   assign rsp_entry_prio = rp_ff;
   assign rsp_last       = rl_ff;
endmodule

// ----- verif/spq_checker.sv -----
`timescale 1ns / 1ps
module spq_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_type,
   input  logic [15:0]        req_tag,
   input  logic signed [15:0] req_prio,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic [4:0]         rsp_occupancy,
   input  logic [15:0]        rsp_entry_tag,
   input  logic signed [15:0] rsp_entry_prio,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 pending
);
   import spq_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         occupancy;
      logic [15:0]        tag;
      logic signed [15:0] prio;
      logic               last;
   } answer_type;

   logic [15:0]        table_tag[CAPACITY];
   logic signed [15:0] table_prio[CAPACITY];
   int                 table_fill;
   answer_type         answers[$];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   function automatic answer_type make_answer(logic [1:0] st, logic [15:0] t,
                                              logic signed [15:0] p, logic l);
      answer_type a;
      a.status = st;
      a.occupancy = table_fill[4:0];
      a.tag = t;
      a.prio = p;
      a.last = l;
      return a;
   endfunction

   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < table_fill; i++) begin
         table_tag[i] = table_tag[i + 1];
         table_prio[i] = table_prio[i + 1];
      end
      table_fill--;
   endfunction

   function automatic bit drop_by_tag(logic [15:0] t);
      for (int i = 0; i < table_fill; i++) begin
         if (table_tag[i] == t) begin
            drop_slot(i);
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic logic [1:0] place_entry(logic [15:0] t, logic signed [15:0] p);
      int pos;
      pos = 0;
      if (table_fill >= CAPACITY) return ST_FULL;
      while (pos < table_fill && table_prio[pos] >= p) pos++;
      for (int i = table_fill; i > pos; i--) begin
         table_tag[i] = table_tag[i - 1];
         table_prio[i] = table_prio[i - 1];
      end
      table_tag[pos] = t;
      table_prio[pos] = p;
      table_fill++;
      return ST_OK;
   endfunction

   function automatic void predict_request(logic [2:0] kind, logic [15:0] t,
                                           logic signed [15:0] p);
      logic [1:0]         st;
      logic [15:0]        head_tag;
      logic signed [15:0] head_prio;
      st = ST_OK;
      case (kind)
         REQ_INSERT: st = place_entry(t, p);
         REQ_REMOVE: st = drop_by_tag(t) ? ST_OK : ST_NOTFOUND;
         REQ_UPDATE: begin
            void'(drop_by_tag(t));
            st = place_entry(t, p);
         end
         REQ_SERVE: begin
            if (table_fill == 0) st = ST_EMPTY;
            else begin
               head_tag = table_tag[0];
               head_prio = table_prio[0];
               drop_slot(0);
               answers.push_back(make_answer(ST_OK, head_tag, head_prio, 1'b1));
               return;
            end
         end
         REQ_LIST: begin
            if (table_fill == 0) st = ST_EMPTY;
            else begin
               for (int i = 0; i < table_fill; i++)
                  answers.push_back(make_answer(ST_OK, table_tag[i], table_prio[i],
                                                i == table_fill - 1));
               return;
            end
         end
         default: ;
      endcase
      answers.push_back(make_answer(st, 16'd0, 16'sd0, 1'b1));
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         table_fill = 0;
         answers.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers.size() == 0) begin
               $display("unexpected response transaction at %0t", $time);
               fail_count++;
            end else begin
               want = answers.pop_front();
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
               if (rsp_occupancy !== want.occupancy)
                  report("occupancy", 32'(rsp_occupancy), 32'(want.occupancy));
               if (rsp_entry_tag !== want.tag)
                  report("entry_tag", 32'(rsp_entry_tag), 32'(want.tag));
               if (rsp_entry_prio !== want.prio)
                  report("entry_prio", 32'(rsp_entry_prio), 32'(want.prio));
               if (rsp_last !== want.last)
                  report("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (req_valid && req_ready) predict_request(req_type, req_tag, req_prio);
      end
      pending <= answers.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import spq_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [2:0]         req_type = REQ_COUNT;
   logic [15:0]        req_tag = 0;
   logic signed [15:0] req_prio = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_occupancy;
   logic [15:0]        rsp_entry_tag;
   logic signed [15:0] rsp_entry_prio;
   logic               rsp_last;
   int                 fail_count;
   int                 pending;
   int                 send_idle = 0;
   int                 sink_stall = 0;
   int                 quiet_cycles = 0;
   logic [15:0]        tag_pool[8];

   localparam int QUIET_LIMIT = 20000;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   stable_priority_queue_table_top i_dut (.*);

   spq_checker i_checker (.*);

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= sink_stall);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Idles at random, then holds the transaction until the block accepts it.
   task automatic send(input logic [2:0] kind, input logic [15:0] t, input logic [15:0] p);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_type <= kind;
      req_tag <= t;
      req_prio <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      logic [2:0]  kind;
      logic [15:0] t;
      logic [15:0] p;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99) < 45 ? REQ_INSERT : 3'($urandom_range(7));
         t = ($urandom_range(3) == 0) ? 16'($urandom) : tag_pool[$urandom_range(7)];
         p = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(6)) - 3);
         send(kind, t, p);
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) tag_pool[i] = 16'($urandom);
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: empty cases, ties, extremes, overflow, update and unused codes.
      send(REQ_SERVE, 16'd0, 16'd0);
      send(REQ_LIST, 16'd0, 16'd0);
      send(REQ_REMOVE, 16'hFFFF, 16'd0);
      send(REQ_INSERT, 16'hFFFF, 16'sh7FFF);
      send(REQ_INSERT, 16'h0000, 16'sh8000);
      send(REQ_INSERT, 16'h1234, 16'sh7FFF);
      send(REQ_UPDATE, 16'h0000, 16'sh7FFF);
      send(REQ_UPDATE, 16'hABCD, 16'h0000);
      send(REQ_LIST, 16'd0, 16'd0);
      send(3'd6, 16'h5555, 16'h5555);
      send(3'd7, 16'hAAAA, 16'hAAAA);
      for (int i = 0; i < 12; i++) send(REQ_INSERT, 16'(i + 100), 16'(i % 3));
      send(REQ_INSERT, 16'h7777, 16'd0);
      send(REQ_UPDATE, 16'h8888, 16'd0);
      send(REQ_UPDATE, 16'h0064, 16'sh8000);
      send(REQ_COUNT, 16'd0, 16'd0);
      send(REQ_LIST, 16'd0, 16'd0);
      send(REQ_SERVE, 16'd0, 16'd0);
      send(REQ_REMOVE, 16'h1234, 16'd0);
      drain();
      random_phase(33);
      send_idle = 74;
      random_phase(33);
      drain();
      send_idle = 0;
      sink_stall = 74;
      random_phase(33);
      send_idle = 23;
      sink_stall = 23;
      random_phase(33);
      drain();
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
